@@ rtl/core/mtep_pkg.sv @@
// Shared types and constants for the multi-turn encoder position unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mtep_pkg;

  // Field widths fixed by the frame format.
  localparam int unsigned FRAME_ID_W = 11;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Default width of the signed per-axis turn counter.
  localparam int unsigned TURN_WIDTH_DEF = 16;

  // Queue between classifier and update pipeline.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // Register reset values.
  localparam logic [FRAME_ID_W-1:0] PITCH_FID_RST = 11'd0;
  localparam logic [FRAME_ID_W-1:0] YAW_ID_RST    = 11'd1;
  localparam logic [ANGLE_W-1:0]    LOW_THR_RST   = 16'd2000;
  localparam logic [ANGLE_W-1:0]    HIGH_THR_RST  = 16'd5000;
  localparam logic [ANGLE_W-1:0]    CPT_RST       = 16'd8191;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PITCH_FID = 3'd0,
    CFG_YAW_ID    = 3'd1,
    CFG_LOW_THR   = 3'd2,
    CFG_HIGH_THR  = 3'd3,
    CFG_CPT       = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    AXIS_PITCH = 1'b0,
    AXIS_YAW   = 1'b1
  } axis_e;

  typedef struct packed {
    logic [FRAME_ID_W-1:0] frame_id;
    logic [7:0]            angle_high;
    logic [7:0]            angle_low;
  } in_item_t;

  typedef struct packed {
    logic                    axis;
    logic signed [POS_W-1:0] position;
  } out_item_t;

  // One classified frame waiting for the update pipeline.
  typedef struct packed {
    logic               axis;
    logic [ANGLE_W-1:0] angle;
  } q_entry_t;

  // Settings used by the update pipeline.
  typedef struct packed {
    logic [ANGLE_W-1:0] low_thr;
    logic [ANGLE_W-1:0] high_thr;
    logic [ANGLE_W-1:0] cpt;
  } back_cfg_t;

endpackage : mtep_pkg

`default_nettype wire

@@ rtl/core/multi_turn_encoder_position_unit.sv @@
// Top level of the multi-turn encoder position unit: configuration registers,
// classifier, queue and update pipeline. Uses mtep_pkg, mtep_front,
// mtep_queue and mtep_back.
//
// Usage: feedback frames enter on the input channel (in_valid_i / in_ready_o,
// payload in_item_i). Frames whose identifier matches the pitch or the yaw
// identifier produce one item on the output channel (out_valid_o /
// out_ready_i, payload out_item_o) with the axis and the unwrapped position;
// all other frames are accepted and dropped without a result.
// From acceptance to out_valid_o an item passes the two-entry queue, the
// unwrap stage, the multiply stage and the output add stage.
// Throughput is one item per cycle when the receiver keeps out_ready_i high.
// When the receiver stalls, the update pipeline holds, and the queue keeps
// taking items until its two entries are full, after which in_ready_o drops.
// Configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i, one register
// per cycle; the user must write only while no item is in flight, unenforced.
// Reset clears the queue, the pipeline, and the per-axis state (no frame
// seen, zero turns), and loads the default identifiers, thresholds and
// counts per turn.
`default_nettype none

module multi_turn_encoder_position_unit #(
  parameter int unsigned TURN_WIDTH = mtep_pkg::TURN_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mtep_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mtep_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire mtep_pkg::in_item_t                in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output mtep_pkg::out_item_t                    out_item_o
);
  import mtep_pkg::*;

  logic [FRAME_ID_W-1:0] pitch_fid_q;
  logic [FRAME_ID_W-1:0] yaw_id_q;
  back_cfg_t             back_cfg_q;

  logic      q_push;
  q_entry_t  q_push_entry;
  logic      q_pop;
  q_entry_t  q_pop_entry;
  logic      q_full;
  logic      q_empty;

  // Configuration registers; writes to unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_fid_q         <= PITCH_FID_RST;
      yaw_id_q            <= YAW_ID_RST;
      back_cfg_q.low_thr  <= LOW_THR_RST;
      back_cfg_q.high_thr <= HIGH_THR_RST;
      back_cfg_q.cpt      <= CPT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PITCH_FID: pitch_fid_q         <= cfg_data_i[FRAME_ID_W-1:0];
        CFG_YAW_ID:    yaw_id_q            <= cfg_data_i[FRAME_ID_W-1:0];
        CFG_LOW_THR:   back_cfg_q.low_thr  <= cfg_data_i;
        CFG_HIGH_THR:  back_cfg_q.high_thr <= cfg_data_i;
        CFG_CPT:       back_cfg_q.cpt      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mtep_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .pitch_fid_i (pitch_fid_q),
    .yaw_id_i    (yaw_id_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_push_entry)
  );

  mtep_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .pop_i        (q_pop),
    .pop_entry_o  (q_pop_entry),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  mtep_back #(
    .TURN_WIDTH (TURN_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (back_cfg_q),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule : multi_turn_encoder_position_unit

`default_nettype wire

@@ rtl/core/mtep_front.sv @@
// Frame classifier: matches the frame identifier against the two axis
// identifiers and forwards matching frames to the queue. Uses mtep_pkg.
`default_nettype none

module mtep_front (
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire mtep_pkg::in_item_t                in_item_i,
  input  wire logic [mtep_pkg::FRAME_ID_W-1:0]   pitch_fid_i,
  input  wire logic [mtep_pkg::FRAME_ID_W-1:0]   yaw_id_i,
  input  wire logic                              q_full_i,
  output logic                                   q_push_o,
  output mtep_pkg::q_entry_t                     q_entry_o
);
  import mtep_pkg::*;

  logic pitch_hit;
  logic yaw_hit;

  // Pitch wins when both identifiers are equal.
  assign pitch_hit = (in_item_i.frame_id == pitch_fid_i);
  assign yaw_hit   = (in_item_i.frame_id == yaw_id_i);

  // Frames that match no axis are accepted and dropped.
  assign in_ready_o      = !q_full_i;
  assign q_push_o        = in_valid_i && !q_full_i && (pitch_hit || yaw_hit);
  assign q_entry_o.axis  = pitch_hit ? AXIS_PITCH : AXIS_YAW;
  assign q_entry_o.angle = {in_item_i.angle_high, in_item_i.angle_low};

endmodule : mtep_front

`default_nettype wire

@@ rtl/core/mtep_queue.sv @@
// Short register queue between the classifier and the update pipeline.
// Uses mtep_pkg for the entry type and depth constants.
`default_nettype none

module mtep_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire mtep_pkg::q_entry_t push_entry_i,
  input  wire logic               pop_i,
  output mtep_pkg::q_entry_t      pop_entry_o,
  output logic                    full_o,
  output logic                    empty_o
);
  import mtep_pkg::*;

  q_entry_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0]  cnt_q, cnt_d;
  logic                    do_push;
  logic                    do_pop;

  assign full_o      = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o     = (cnt_q == '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule : mtep_queue

`default_nettype wire

@@ rtl/core/mtep_back.sv @@
// Update pipeline: per-axis unwrap state, turn counting, and the position
// multiply-add over three register stages. Uses mtep_pkg.
`default_nettype none

module mtep_back #(
  parameter int unsigned TURN_WIDTH = mtep_pkg::TURN_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mtep_pkg::back_cfg_t cfg_i,
  input  wire logic                q_empty_i,
  input  wire mtep_pkg::q_entry_t  q_entry_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output mtep_pkg::out_item_t      out_item_o
);
  import mtep_pkg::*;

  localparam int unsigned PROD_W = TURN_WIDTH + ANGLE_W + 1;
  localparam int unsigned SUM_W  = (PROD_W + 1 > POS_W) ? PROD_W + 1 : POS_W;
  localparam logic signed [TURN_WIDTH-1:0] TurnMax = {1'b0, {(TURN_WIDTH-1){1'b1}}};
  localparam logic signed [TURN_WIDTH-1:0] TurnMin = {1'b1, {(TURN_WIDTH-1){1'b0}}};

  // Per-axis state.
  logic                          seen_q [2];
  logic                          seen_d [2];
  logic [ANGLE_W-1:0]            off_q  [2];
  logic [ANGLE_W-1:0]            off_d  [2];
  logic [ANGLE_W-1:0]            prev_q [2];
  logic [ANGLE_W-1:0]            prev_d [2];
  logic signed [TURN_WIDTH-1:0]  turn_q [2];
  logic signed [TURN_WIDTH-1:0]  turn_d [2];

  // Pipeline stages.
  logic                          adv;
  logic                          a_valid_q;
  logic                          a_axis_q;
  logic signed [TURN_WIDTH-1:0]  a_turn_q, a_turn_d;
  logic signed [ANGLE_W:0]       a_diff_q, a_diff_d;
  logic                          b_valid_q;
  logic                          b_axis_q;
  logic signed [PROD_W-1:0]      b_prod_q, b_prod_d;
  logic signed [ANGLE_W:0]       b_diff_q;
  logic                          out_valid_q;
  out_item_t                     out_item_q, out_item_d;

  logic                          ax;
  logic [ANGLE_W-1:0]            ang;
  logic [ANGLE_W-1:0]            prev_eff;
  logic [ANGLE_W-1:0]            off_eff;
  logic signed [TURN_WIDTH-1:0]  turn_cur;
  logic                          wrap_up;
  logic                          wrap_down;
  logic signed [SUM_W-1:0]       sum;

  // The whole pipeline moves when the output register is free or being drained.
  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = adv && !q_empty_i;

  assign ax  = q_entry_i.axis;
  assign ang = q_entry_i.angle;

  always_comb begin
    // A first frame acts as its own previous angle and zero offset.
    prev_eff  = seen_q[ax] ? prev_q[ax] : ang;
    off_eff   = seen_q[ax] ? off_q[ax]  : ang;
    turn_cur  = turn_q[ax];
    wrap_up   = (ang < cfg_i.low_thr) && (prev_eff > cfg_i.high_thr);
    wrap_down = (ang > cfg_i.high_thr) && (prev_eff < cfg_i.low_thr);

    a_turn_d = turn_cur;
    if (wrap_up) begin
      if (turn_cur != TurnMax) begin
        a_turn_d = turn_cur + 1'b1;
      end
    end else if (wrap_down) begin
      if (turn_cur != TurnMin) begin
        a_turn_d = turn_cur - 1'b1;
      end
    end
    a_diff_d = signed'({1'b0, ang}) - signed'({1'b0, off_eff});

    seen_d = seen_q;
    off_d  = off_q;
    prev_d = prev_q;
    turn_d = turn_q;
    if (q_pop_o) begin
      seen_d[ax] = 1'b1;
      off_d[ax]  = off_eff;
      prev_d[ax] = ang;
      turn_d[ax] = a_turn_d;
    end
  end

  always_comb begin
    b_prod_d = a_turn_q * signed'({1'b0, cfg_i.cpt});
    // Exact sum, then wrapped to the position width.
    sum      = SUM_W'(b_prod_q) + SUM_W'(b_diff_q);
    out_item_d.axis     = b_axis_q;
    out_item_d.position = sum[POS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        seen_q[i] <= 1'b0;
        off_q[i]  <= '0;
        prev_q[i] <= '0;
        turn_q[i] <= '0;
      end
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
      off_q  <= off_d;
      prev_q <= prev_d;
      turn_q <= turn_d;
      if (adv) begin
        a_valid_q   <= q_pop_o;
        b_valid_q   <= a_valid_q;
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_axis_q   <= ax;
      a_turn_q   <= a_turn_d;
      a_diff_q   <= a_diff_d;
      b_axis_q   <= a_axis_q;
      b_prod_q   <= b_prod_d;
      b_diff_q   <= a_diff_q;
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule : mtep_back

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for multi_turn_encoder_position_unit: directed, turn counting
// and random feedback frames, each result checked against a behavioral position model.
// Depends on mtep_pkg and the RTL of the unit only.

module testbench;
  import mtep_pkg::*;

  // The unit is built with its default turn counter width, and the model follows it.
  localparam int     TURN_W      = 16;
  localparam longint TURN_MAX    = (longint'(1) << (TURN_W - 1)) - 1;
  localparam longint TURN_MIN    = -TURN_MAX - 1;
  localparam int     CYCLE_LIMIT = 1000000;
  // Cycles idled with the receiver ready after the last owed result has come.
  localparam int     SETTLE_CYCLES = 16;
  localparam int     RANDOM_HITS   = 110;
  // Turns counted each way by the turn counting test.
  localparam int     WRAP_TURNS    = 20;

  // Mirror of the configuration registers.
  typedef struct packed {
    logic [FRAME_ID_W-1:0] pitch_fid;
    logic [FRAME_ID_W-1:0] yaw_id;
    logic [ANGLE_W-1:0]    low_thr;
    logic [ANGLE_W-1:0]    high_thr;
    logic [ANGLE_W-1:0]    cpt;
  } settings_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  cfg_idx_e              cfg_idx   = CFG_PITCH_FID;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;

  // Model of the unit: register copy plus the per-axis unwrap state.
  settings_t         cur_settings = '{PITCH_FID_RST, YAW_ID_RST, LOW_THR_RST, HIGH_THR_RST,
                                      CPT_RST};
  bit                axis_seen   [2] = '{default: 1'b0};
  logic [ANGLE_W-1:0] axis_offset [2] = '{default: '0};
  logic [ANGLE_W-1:0] axis_prev   [2] = '{default: '0};
  longint            axis_turns  [2] = '{default: 0};

  // Positions still owed by the unit, oldest first.
  out_item_t pending_positions[$];
  int        results_due   = 0;
  int        error_count   = 0;
  int        cycle_count   = 0;
  int        send_gap_pct  = 0;
  int        ready_stall_pct = 0;
  // Per-lane angle (pitch, yaw, any identifier) that the random walk moves around the circle.
  logic [ANGLE_W-1:0] walk_angle [3] = '{default: '0};

  multi_turn_encoder_position_unit #(
    .TURN_WIDTH(TURN_W)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit, far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL multi_turn_encoder_position_unit");
      $finish;
    end
  end

  // The receiver stalls at random; the rate is set per phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  // Every result taken from the unit is matched against the oldest owed position.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_positions.size() == 0) begin
        $error("unexpected result: axis %0d position %0d", out_item.axis, out_item.position);
        error_count++;
      end else begin
        want = pending_positions.pop_front();
        if (out_item.axis !== want.axis) begin
          $error("axis: expected %0d, got %0d", want.axis, out_item.axis);
          error_count++;
        end
        if (out_item.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_item.position);
          error_count++;
        end
      end
    end
  end

  // Runs one accepted frame through the model. Returns 1 when the frame belongs to an
  // axis, with the position the unit must report; 0 when the unit drops it.
  function automatic bit unwrap_frame(input in_item_t frame, output out_item_t result);
    logic [ANGLE_W-1:0] angle;
    axis_e              ax;
    longint             pos;
    angle  = {frame.angle_high, frame.angle_low};
    result = '0;
    // Pitch is matched first, so a shared identifier never reaches yaw.
    if (frame.frame_id == cur_settings.pitch_fid) ax = AXIS_PITCH;
    else if (frame.frame_id == cur_settings.yaw_id) ax = AXIS_YAW;
    else return 1'b0;
    // The first frame on an axis becomes its zero, and also its previous angle, so
    // inverted thresholds can already count a turn on that first frame.
    if (!axis_seen[ax]) begin
      axis_offset[ax] = angle;
      axis_prev[ax]   = angle;
      axis_seen[ax]   = 1'b1;
    end
    if (angle < cur_settings.low_thr && axis_prev[ax] > cur_settings.high_thr) begin
      if (axis_turns[ax] < TURN_MAX) axis_turns[ax]++;
    end else if (angle > cur_settings.high_thr && axis_prev[ax] < cur_settings.low_thr) begin
      if (axis_turns[ax] > TURN_MIN) axis_turns[ax]--;
    end
    axis_prev[ax] = angle;
    // Formed exactly in 64 bits, then cut to the 32-bit result.
    pos = axis_turns[ax] * longint'(cur_settings.cpt) + longint'(angle)
          - longint'(axis_offset[ax]);
    result.axis     = ax;
    result.position = pos[POS_W-1:0];
    return 1'b1;
  endfunction

  // Offers one frame and returns at the falling edge after it is accepted. Valid is
  // left high so that back-to-back frames go at full rate; a random gap lowers it.
  task automatic send_frame(input logic [FRAME_ID_W-1:0] id, input logic [ANGLE_W-1:0] angle);
    in_item_t  frame;
    out_item_t result;
    frame.frame_id   = id;
    frame.angle_high = angle[15:8];
    frame.angle_low  = angle[7:0];
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_item  <= frame;
    do @(posedge clk); while (!in_ready);
    if (unwrap_frame(frame, result)) begin
      pending_positions.push_back(result);
      results_due++;
    end
    @(negedge clk);
  endtask

  // Stops sending and waits until every owed position has come, then idles for
  // SETTLE_CYCLES with the receiver ready; dropped frames never enter the pipeline.
  task automatic wait_for_results();
    int saved_stall;
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(negedge clk);
    saved_stall     = ready_stall_pct;
    ready_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    ready_stall_pct = saved_stall;
  endtask

  // Writes all five registers on consecutive cycles; the unit must be idle.
  task automatic apply_settings(input logic [FRAME_ID_W-1:0] pitch_fid,
                                input logic [FRAME_ID_W-1:0] yaw_id,
                                input logic [ANGLE_W-1:0] low_thr,
                                input logic [ANGLE_W-1:0] high_thr,
                                input logic [ANGLE_W-1:0] cpt);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PITCH_FID;
    cfg_data <= CFG_DATA_W'(pitch_fid);
    @(negedge clk);
    cfg_idx  <= CFG_YAW_ID;
    cfg_data <= CFG_DATA_W'(yaw_id);
    @(negedge clk);
    cfg_idx  <= CFG_LOW_THR;
    cfg_data <= low_thr;
    @(negedge clk);
    cfg_idx  <= CFG_HIGH_THR;
    cfg_data <= high_thr;
    @(negedge clk);
    cfg_idx  <= CFG_CPT;
    cfg_data <= cpt;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_settings = '{pitch_fid, yaw_id, low_thr, high_thr, cpt};
  endtask

  // Reset values in force: the first pitch frame sits at the top of the range, so
  // later pitch positions come out negative. Foreign identifiers drop.
  task automatic test_reset_defaults();
    send_frame(11'd0, 16'hFFFF);
    send_frame(11'd2, 16'h0000);
    send_frame(11'h7FF, 16'hAAAA);
    send_frame(11'd0, 16'h0000);
    wait_for_results();
  endtask

  // Inverted thresholds: the very first yaw frame already counts a turn because its
  // previous angle is itself and lies between the two limits.
  task automatic test_inverted_first_frame();
    apply_settings(11'd0, 11'd1, 16'd60000, 16'd100, 16'd8191);
    send_frame(11'd1, 16'd30000);
    send_frame(11'd1, 16'd30000);
    send_frame(11'd1, 16'h5555);
    send_frame(11'd0, 16'h00FF);
    send_frame(11'd0, 16'hFF00);
    wait_for_results();
  endtask

  // Ordinary wrap both ways at the default thresholds, including values just at and
  // just past each threshold, where the comparisons are strict.
  task automatic test_wrap_both_ways();
    apply_settings(11'd0, 11'd1, 16'd2000, 16'd5000, 16'd8191);
    send_frame(11'd0, 16'd6000);
    send_frame(11'd0, 16'd1000);
    send_frame(11'd0, 16'd6000);
    send_frame(11'd0, 16'd5000);
    send_frame(11'd0, 16'd1999);
    send_frame(11'd1, 16'd2000);
    send_frame(11'd1, 16'd5001);
    send_frame(11'd1, 16'd1999);
    send_frame(11'd1, 16'd5001);
    wait_for_results();
  endtask

  // One identifier on both axes: pitch takes every such frame.
  task automatic test_shared_id();
    apply_settings(11'h555, 11'h555, 16'd2000, 16'd5000, 16'd1);
    send_frame(11'h555, 16'd7000);
    send_frame(11'h555, 16'd100);
    send_frame(11'h2AA, 16'd100);
    send_frame(11'h555, 16'hFFFF);
    wait_for_results();
  endtask

  // Zero counts per turn and identifiers at both ends of their range. With a zero
  // low threshold no turn can ever be counted.
  task automatic test_zero_cpt();
    apply_settings(11'h7FF, 11'h000, 16'd0, 16'd65535, 16'd0);
    send_frame(11'h7FF, 16'hFFFF);
    send_frame(11'h000, 16'h1234);
    send_frame(11'h7FF, 16'h0000);
    send_frame(11'h3FF, 16'h8000);
    wait_for_results();
  endtask

  // Counts pitch several turns down and yaw several turns up, with the largest counts
  // per turn, so that the product term dominates the position.
  task automatic test_turn_counting();
    apply_settings(11'h123, 11'h321, 16'd2000, 16'd5000, 16'd65535);
    // Low, high, middle: one turn down per three frames with no turn up between.
    for (int i = 0; i < WRAP_TURNS; i++) begin
      send_frame(11'h123, 16'd0);
      send_frame(11'h123, 16'd65535);
      send_frame(11'h123, 16'd3000);
    end
    send_frame(11'h123, 16'd0);
    wait_for_results();
    // With inverted thresholds a steady middle angle counts one turn up per frame.
    apply_settings(11'h123, 11'h321, 16'd60000, 16'd100, 16'd65535);
    for (int i = 0; i < WRAP_TURNS; i++) begin
      send_frame(11'h321, 16'd30000);
    end
    send_frame(11'h321, 16'hFFFF);
    wait_for_results();
  endtask

  // One random phase: fresh settings, then frames until enough results are owed. Most
  // frames walk each axis around the circle so that turns are crossed both ways.
  task automatic test_random_phase(input int gap_pct, input int stall_pct);
    logic [FRAME_ID_W-1:0] pitch_fid, yaw_id, id;
    logic [ANGLE_W-1:0]    low_thr, high_thr, cpt, angle;
    int                    start, lane;
    bit                    paused;
    pitch_fid = FRAME_ID_W'($urandom);
    yaw_id    = ($urandom_range(7) == 0) ? pitch_fid : FRAME_ID_W'($urandom);
    case ($urandom_range(4))
      0: begin low_thr = 16'd0;     high_thr = 16'd65535; end
      1: begin low_thr = 16'd65535; high_thr = 16'd0;     end
      2: begin low_thr = 16'($urandom); high_thr = 16'($urandom); end
      default: begin
        low_thr  = 16'($urandom_range(20000, 500));
        high_thr = low_thr + 16'($urandom_range(40000, 0));
      end
    endcase
    case ($urandom_range(4))
      0: cpt = 16'd0;
      1: cpt = 16'd1;
      2: cpt = 16'd65535;
      default: cpt = 16'($urandom);
    endcase
    apply_settings(pitch_fid, yaw_id, low_thr, high_thr, cpt);
    send_gap_pct    = gap_pct;
    ready_stall_pct = stall_pct;
    start  = results_due;
    paused = 1'b0;
    while (results_due - start < RANDOM_HITS) begin
      // Lane 0 is pitch, 1 yaw, 2 any identifier at all.
      if ($urandom_range(99) < 45) lane = 0;
      else if ($urandom_range(99) < 75) lane = 1;
      else lane = 2;
      id = (lane == 0) ? pitch_fid : (lane == 1) ? yaw_id : FRAME_ID_W'($urandom);
      case ($urandom_range(9))
        0: angle = 16'($urandom);
        1: begin
          case ($urandom_range(5))
            0: angle = 16'd0;
            1: angle = 16'hFFFF;
            2: angle = low_thr;
            3: angle = low_thr - 16'd1;
            4: angle = high_thr;
            default: angle = high_thr + 16'd1;
          endcase
        end
        default: angle = walk_angle[lane] + 16'($urandom_range(16000, 0)) - 16'd8000;
      endcase
      walk_angle[lane] = angle;
      send_frame(id, angle);
      // Halfway through, hold off until the unit has delivered everything.
      if (!paused && results_due - start >= RANDOM_HITS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_inverted_first_frame();
    test_wrap_both_ways();
    test_shared_id();
    test_zero_cpt();
    test_turn_counting();
    test_random_phase(0, 0);
    test_random_phase(69, 0);
    test_random_phase(0, 69);
    test_random_phase(33, 33);

    wait_for_results();
    if (error_count == 0) begin
      $display("PASS multi_turn_encoder_position_unit");
    end else begin
      $display("FAIL multi_turn_encoder_position_unit");
    end
    $finish;
  end

endmodule
